// ----- rtl/flow_control_execute_unit_top_macros.svh -----
// assertion macros shared by the flow control execute unit checker
// no dependencies; the including module must have clock and reset in scope
`ifndef FLOW_CONTROL_EXECUTE_UNIT_TOP_MACROS_SVH
`define FLOW_CONTROL_EXECUTE_UNIT_TOP_MACROS_SVH

// checked only outside reset
`define FCU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define FCU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/fcu_pkg.sv -----
// types and constants for the flow control execute unit
// no dependencies
package fcu_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int SP_W        = $clog2(STACK_DEPTH);

   // csr register index of the brk vector
   localparam logic CSR_IDX_BREAK = 1'b0;

   // opcodes
   localparam logic [7:0] OP_BRK    = 8'h00;
   localparam logic [7:0] OP_NOP    = 8'hEA;
   localparam logic [7:0] OP_BIT_ZP = 8'h24;
   localparam logic [7:0] OP_BIT_AB = 8'h2C;
   localparam logic [7:0] OP_CLC    = 8'h18;
   localparam logic [7:0] OP_SEC    = 8'h38;
   localparam logic [7:0] OP_CLI    = 8'h58;
   localparam logic [7:0] OP_SEI    = 8'h78;
   localparam logic [7:0] OP_CLV    = 8'hB8;
   localparam logic [7:0] OP_CLD    = 8'hD8;
   localparam logic [7:0] OP_SED    = 8'hF8;
   localparam logic [7:0] OP_BPL    = 8'h10;
   localparam logic [7:0] OP_BMI    = 8'h30;
   localparam logic [7:0] OP_BVC    = 8'h50;
   localparam logic [7:0] OP_BVS    = 8'h70;
   localparam logic [7:0] OP_BCC    = 8'h90;
   localparam logic [7:0] OP_BCS    = 8'hB0;
   localparam logic [7:0] OP_BNE    = 8'hD0;
   localparam logic [7:0] OP_BEQ    = 8'hF0;
   localparam logic [7:0] OP_JMP_AB = 8'h4C;
   localparam logic [7:0] OP_JMP_IN = 8'h6C;
   localparam logic [7:0] OP_JSR    = 8'h20;
   localparam logic [7:0] OP_RTS    = 8'h60;
   localparam logic [7:0] OP_RTI    = 8'h40;

   // status flag masks
   localparam logic [7:0] F_C = 8'h01;
   localparam logic [7:0] F_Z = 8'h02;
   localparam logic [7:0] F_I = 8'h04;
   localparam logic [7:0] F_D = 8'h08;
   localparam logic [7:0] F_B = 8'h10;
   localparam logic [7:0] F_U = 8'h20;
   localparam logic [7:0] F_V = 8'h40;
   localparam logic [7:0] F_N = 8'h80;

   localparam logic [7:0] BIT_KEEP_MASK = 8'h3D;
   localparam logic [7:0] CLC_MASK      = 8'hFE;
   localparam logic [7:0] CLI_MASK      = 8'hFB;
   localparam logic [7:0] CLV_MASK      = 8'hBF;
   localparam logic [7:0] CLD_MASK      = 8'hF7;

   localparam logic [SP_W-1:0] SP_EMPTY = SP_W'(STACK_DEPTH - 1);

   // request item, operation in the low bits
   typedef struct packed {
      logic [7:0]  acc;
      logic [7:0]  mem_hi;
      logic [7:0]  mem_lo;
      logic [15:0] operand;
      logic [7:0]  operation;
   } req_item_type;

   // result item, next_pc in the low bits
   typedef struct packed {
      logic            unsupported;
      logic            halted;
      logic            branch_taken;
      logic [SP_W-1:0] stack_ptr;
      logic [7:0]      status;
      logic [15:0]     next_pc;
   } rsp_item_type;

   localparam int RSP_ITEM_W = $bits(rsp_item_type);
   localparam int RSP_DATA_W = ((RSP_ITEM_W + 7) / 8) * 8;

   typedef logic [1:0] step_type;

   typedef struct packed {
      logic            en;
      logic [SP_W-1:0] addr;
      logic [7:0]      data;
   } ram_wr_type;

   typedef struct packed {
      logic            en;
      logic [SP_W-1:0] addr;
   } ram_rd_type;

endpackage

// ----- rtl/fcu_stack_ram.sv -----
// stack page memory: one write port, one registered read port
// depends on fcu_pkg
module fcu_stack_ram
   import fcu_pkg::*;
(
   input  logic       clock,
   input  ram_wr_type wr,
   input  ram_rd_type rd,
   output logic [7:0] rd_data_ff
);

   logic [7:0] mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

endmodule

// ----- rtl/fcu_exec.sv -----
// execute stage: architectural state, stack sequencer and result build
// depends on fcu_pkg and drives fcu_stack_ram through the top level
module fcu_exec
   import fcu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  req_item_type in_item,
   input  logic         out_free,
   input  logic [15:0]  break_vector,
   input  logic [7:0]   rd_data,
   output ram_wr_type   ram_wr,
   output ram_rd_type   ram_rd,
   output logic         finish,
   output rsp_item_type result
);

   logic [15:0]     pc_ff, pc_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [7:0]      flags_ff, flags_in;
   logic            stopped_ff, stopped_in;
   step_type        step_ff, step_in;
   logic [7:0]      byte0_ff, byte0_in;
   logic [7:0]      byte1_ff, byte1_in;

   logic            advance;
   step_type        last_step;
   logic [15:0]     ret_addr;
   logic [15:0]     br_base;
   logic [15:0]     br_off;
   logic            is_branch;
   logic            cond;
   logic            taken;
   logic            unsup;
   logic            stop_now;
   logic [7:0]      bit_flags;
   logic [7:0]      op;

   assign op       = in_item.operation;
   assign advance  = in_valid && out_free;
   assign ret_addr = pc_ff + 16'd2;
   assign br_base  = pc_ff + 16'd2;
   assign br_off   = {{8{in_item.operand[7]}}, in_item.operand[7:0]};

   always_comb begin
      bit_flags = (flags_ff & BIT_KEEP_MASK) | (in_item.mem_lo & (F_N | F_V));
      if ((in_item.mem_lo & in_item.acc) == 8'd0) begin
         bit_flags = bit_flags | F_Z;
      end
   end

   // last sequencer step of the stack traffic for each opcode
   always_comb begin
      last_step = 2'd0;
      if (!stopped_ff) begin
         case (op)
            OP_BRK:  last_step = (sp_ff < SP_W'(3))        ? 2'd0 : 2'd2;
            OP_JSR:  last_step = (sp_ff < SP_W'(2))        ? 2'd0 : 2'd1;
            OP_RTS:  last_step = (sp_ff > SP_W'(8'hFD))    ? 2'd0 : 2'd2;
            OP_RTI:  last_step = (sp_ff > SP_W'(8'hFC))    ? 2'd0 : 2'd3;
            default: last_step = 2'd0;
         endcase
      end
   end

   assign finish = advance && (step_ff == last_step);

   // stack port control
   always_comb begin
      ram_wr.en   = advance && !stopped_ff &&
                    (((op == OP_BRK) && (sp_ff >= SP_W'(3))) ||
                     ((op == OP_JSR) && (sp_ff >= SP_W'(2))));
      ram_wr.addr = sp_ff - SP_W'(step_ff);
      case (step_ff)
         2'd0:    ram_wr.data = ret_addr[15:8];
         2'd1:    ram_wr.data = ret_addr[7:0];
         default: ram_wr.data = flags_ff | F_U | F_B;
      endcase
      ram_rd.en   = advance;
      ram_rd.addr = sp_ff + SP_W'(1) + SP_W'(step_ff);
   end

   always_comb begin
      byte0_in = byte0_ff;
      byte1_in = byte1_ff;
      step_in  = step_ff;
      if (advance) begin
         if (step_ff == 2'd1) begin
            byte0_in = rd_data;
         end
         if (step_ff == 2'd2) begin
            byte1_in = rd_data;
         end
         step_in = finish ? 2'd0 : step_ff + 2'd1;
      end
   end

   // instruction effect, committed on finish
   always_comb begin
      pc_in      = pc_ff;
      sp_in      = sp_ff;
      flags_in   = flags_ff;
      stopped_in = stopped_ff;
      is_branch  = 1'b0;
      cond       = 1'b0;
      unsup      = 1'b0;
      stop_now   = 1'b0;
      case (op)
         OP_BRK: begin
            if (sp_ff < SP_W'(3)) begin
               stop_now = 1'b1;
            end else begin
               sp_in    = sp_ff - SP_W'(3);
               flags_in = flags_ff | F_I;
               pc_in    = break_vector;
            end
         end
         OP_NOP:    pc_in = pc_ff + 16'd1;
         OP_BIT_ZP: begin
            flags_in = bit_flags;
            pc_in    = pc_ff + 16'd2;
         end
         OP_BIT_AB: begin
            flags_in = bit_flags;
            pc_in    = pc_ff + 16'd3;
         end
         OP_CLC: begin flags_in = flags_ff & CLC_MASK; pc_in = pc_ff + 16'd1; end
         OP_SEC: begin flags_in = flags_ff | F_C;      pc_in = pc_ff + 16'd1; end
         OP_CLI: begin flags_in = flags_ff & CLI_MASK; pc_in = pc_ff + 16'd1; end
         OP_SEI: begin flags_in = flags_ff | F_I;      pc_in = pc_ff + 16'd1; end
         OP_CLV: begin flags_in = flags_ff & CLV_MASK; pc_in = pc_ff + 16'd1; end
         OP_CLD: begin flags_in = flags_ff & CLD_MASK; pc_in = pc_ff + 16'd1; end
         OP_SED: begin flags_in = flags_ff | F_D;      pc_in = pc_ff + 16'd1; end
         OP_BPL: begin is_branch = 1'b1; cond = (flags_ff & F_N) == 8'd0; end
         OP_BMI: begin is_branch = 1'b1; cond = (flags_ff & F_N) != 8'd0; end
         OP_BVC: begin is_branch = 1'b1; cond = (flags_ff & F_V) == 8'd0; end
         OP_BVS: begin is_branch = 1'b1; cond = (flags_ff & F_V) != 8'd0; end
         OP_BCC: begin is_branch = 1'b1; cond = (flags_ff & F_C) == 8'd0; end
         OP_BCS: begin is_branch = 1'b1; cond = (flags_ff & F_C) != 8'd0; end
         OP_BNE: begin is_branch = 1'b1; cond = (flags_ff & F_Z) == 8'd0; end
         OP_BEQ: begin is_branch = 1'b1; cond = (flags_ff & F_Z) != 8'd0; end
         OP_JMP_AB: begin
            if (in_item.operand == pc_ff) begin
               stop_now = 1'b1;
            end else begin
               pc_in = in_item.operand;
            end
         end
         OP_JMP_IN: pc_in = {in_item.mem_hi, in_item.mem_lo};
         OP_JSR: begin
            if (sp_ff < SP_W'(2)) begin
               stop_now = 1'b1;
            end else begin
               sp_in = sp_ff - SP_W'(2);
               pc_in = in_item.operand;
            end
         end
         OP_RTS: begin
            if (sp_ff > SP_W'(8'hFD)) begin
               stop_now = 1'b1;
            end else begin
               sp_in = sp_ff + SP_W'(2);
               pc_in = {rd_data, byte0_ff} + 16'd1;
            end
         end
         OP_RTI: begin
            if (sp_ff > SP_W'(8'hFC)) begin
               stop_now = 1'b1;
            end else begin
               // interrupt return that empties the stack completes, then halts
               sp_in    = sp_ff + SP_W'(3);
               flags_in = byte0_ff;
               pc_in    = {rd_data, byte1_ff};
               stop_now = (sp_ff + SP_W'(3)) == SP_EMPTY;
            end
         end
         default: unsup = 1'b1;
      endcase
      if (is_branch) begin
         pc_in = cond ? br_base + br_off : br_base;
      end
      taken = is_branch && cond;
      if (stop_now) begin
         stopped_in = 1'b1;
      end
      // a halted unit ignores everything
      if (stopped_ff) begin
         pc_in    = pc_ff;
         sp_in    = sp_ff;
         flags_in = flags_ff;
         taken    = 1'b0;
         unsup    = 1'b0;
      end
      result.next_pc      = pc_in;
      result.status       = flags_in;
      result.stack_ptr    = sp_in;
      result.branch_taken = taken;
      result.halted       = stopped_in;
      result.unsupported  = unsup;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= 16'd0;
         sp_ff      <= SP_EMPTY;
         flags_ff   <= 8'd0;
         stopped_ff <= 1'b0;
         step_ff    <= 2'd0;
      end else begin
         step_ff <= step_in;
         if (finish) begin
            pc_ff      <= pc_in;
            sp_ff      <= sp_in;
            flags_ff   <= flags_in;
            stopped_ff <= stopped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte0_ff <= byte0_in;
      byte1_ff <= byte1_in;
   end

endmodule

// ----- rtl/flow_control_execute_unit_top.sv -----
// top level of the flow control execute unit: request register, csr port, result register
// depends on fcu_pkg, fcu_exec and fcu_stack_ram
//
// executes 6502 branch, jump, flag, bit and stack instructions, one request per item
// request channel req_*: one decoded instruction (opcode, operand, memory bytes, acc)
// result channel rsp_*: next pc, status flags, stack pointer and three indicator bits
// csr port csr_*: apb-style, register 0 at address 0 holds the brk vector
// a request passes from the request register through the combinational execute
// stage into the result register; jsr and brk push and rts and rti pop the stack
// page one byte per sequencer step, and the page has one write and one read port
// non-stack opcodes take a new request every clock while results are not stalled;
// a stack opcode holds the request register until its last stack byte is done
// a request register in front of the execute stage and a result register behind it
// let a new request be taken while a finished result still waits
// when the receiver stalls, the result holds and the execute stage waits; the
// request register still takes one more request
// reset: pc 0, stack pointer 0xff, flags 0, unit running, brk vector 0
// the stack page is not cleared; pops only read bytes that pushes wrote
// once halted, every request returns the frozen state with halted set
module flow_control_execute_unit_top
   import fcu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request: operation, operand, mem_lo, mem_hi, acc from bit 0 up
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,
   // result: next_pc, status, stack_ptr, branch_taken, halted, unsupported from bit 0 up,
   // zero padded
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // csr port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // request register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   // brk vector register
   logic [15:0]  break_vector_ff, break_vector_in;

   logic         req_fire;
   logic         out_free;
   logic         finish;
   rsp_item_type result;
   ram_wr_type   ram_wr;
   ram_rd_type   ram_rd;
   logic [7:0]   rd_data;
   logic         csr_wr;

   // request register frees up when the execute stage finishes its item
   assign req_tready  = !in_valid_ff || finish;
   assign req_fire    = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item_type'(req_tdata);
      end else if (finish) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_item_ff);

   // csr write at the access phase
   assign csr_pready      = 1'b1;
   assign csr_wr          = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign break_vector_in = (csr_wr && (csr_paddr[2] == CSR_IDX_BREAK)) ?
                            csr_pwdata[15:0] : break_vector_ff;
   assign csr_prdata      = (csr_paddr[2] == CSR_IDX_BREAK) ?
                            {16'd0, break_vector_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         break_vector_ff <= 16'd0;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         break_vector_ff <= break_vector_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   fcu_exec u_exec (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (in_valid_ff),
      .in_item      (in_item_ff),
      .out_free     (out_free),
      .break_vector (break_vector_ff),
      .rd_data      (rd_data),
      .ram_wr       (ram_wr),
      .ram_rd       (ram_rd),
      .finish       (finish),
      .result       (result)
   );

   fcu_stack_ram u_stack (
      .clock      (clock),
      .wr         (ram_wr),
      .rd         (ram_rd),
      .rd_data_ff (rd_data)
   );

endmodule

// ----- rtl/fcu_checker.sv -----
// port-level checker for the flow control execute unit, bound to the top level
// depends on fcu_pkg and flow_control_execute_unit_top_macros.svh
`include "flow_control_execute_unit_top_macros.svh"

module fcu_checker
   import fcu_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [2:0]            csr_paddr,
   input logic [31:0]           csr_pwdata,
   input logic [31:0]           csr_prdata,
   input logic                  csr_pready
);

   rsp_item_type rsp_item;
   logic         rsp_stall;
   logic         halt_out;
   logic         side_bits;
   logic         brk_sel;
   logic         brk_wr;
   logic [15:0]  wdata16;
   logic [15:0]  rdata16;

   assign rsp_item  = rsp_item_type'(rsp_tdata[RSP_ITEM_W-1:0]);
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign halt_out  = rsp_tvalid && rsp_item.halted;
   assign side_bits = rsp_item.branch_taken || rsp_item.unsupported;
   assign brk_sel   = csr_paddr[2] == CSR_IDX_BREAK;
   assign brk_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready && brk_sel;
   assign wdata16   = csr_pwdata[15:0];
   assign rdata16   = csr_prdata[15:0];

   // a stalled result keeps its payload
   `FCU_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // no result right after reset
   `FCU_ASSERT_ALWAYS(a_rsp_reset, reset |=> !rsp_tvalid, "result valid after reset")

   // a halted result never reports a taken branch or an unknown opcode
   `FCU_ASSERT(a_halt_flags, halt_out |-> !side_bits, "halted with branch or unsupported")

   // brk vector reads back what was written
   `FCU_ASSERT(a_brk_readback, $past(brk_wr) && brk_sel |-> rdata16 == $past(wdata16), "brk readback")

endmodule

bind flow_control_execute_unit_top fcu_checker u_fcu_checker (.*);

// ----- bench/tb.sv -----
// self-checking bench for flow_control_execute_unit_top: 6502 flow, flag and stack opcodes
// depends on fcu_pkg and the rtl; a bench cpu model predicts each result not typed in

module tb;
   import fcu_pkg::*;

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          IDLE_CYCLES  = 8;
   localparam int          SCRIPT_LEN   = 27;
   localparam logic [2:0]  REG_BRK_VEC  = 3'd0;
   localparam logic [7:0]  OP_UNKNOWN   = 8'hFF;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [47:0]           req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [2:0]            csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   flow_control_execute_unit_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // architectural state of the cpu as the bench sees it
   logic [15:0]  arch_pc;
   logic [7:0]   arch_sp;
   logic [7:0]   arch_flags;
   logic [7:0]   arch_stack [STACK_DEPTH];
   logic         arch_halted;
   logic [15:0]  brk_vector;

   // outcomes of accepted requests, oldest first
   rsp_item_type instr_outcomes [$];

   int           mismatches;
   int unsigned  cycle_count;
   int           req_calm;
   int           rsp_calm;
   bit           stack_dive;

   // one directed row: request, whether a hand-typed outcome applies, that outcome
   typedef struct packed {
      req_item_type stim;
      logic         typed;
      rsp_item_type want;
   } script_row_type;

   script_row_type script [SCRIPT_LEN];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      cycle_count = 0;
      wait (cycle_count == CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // wait per item: usually a random gap, sometimes a burst with no gaps at all
   function automatic int pick_wait(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic req_item_type stim(input logic [7:0] op, input logic [15:0] opnd,
                                         input logic [7:0] mlo, input logic [7:0] mhi,
                                         input logic [7:0] acc);
      req_item_type rq;
      rq.operation = op;
      rq.operand   = opnd;
      rq.mem_lo    = mlo;
      rq.mem_hi    = mhi;
      rq.acc       = acc;
      return rq;
   endfunction

   function automatic rsp_item_type want(input logic [15:0] pc, input logic [7:0] st,
                                         input logic [7:0] sp, input logic taken,
                                         input logic halt, input logic unsup);
      rsp_item_type rs;
      rs.next_pc      = pc;
      rs.status       = st;
      rs.stack_ptr    = sp;
      rs.branch_taken = taken;
      rs.halted       = halt;
      rs.unsupported  = unsup;
      return rs;
   endfunction

   function automatic void stack_push(input logic [7:0] value);
      arch_stack[arch_sp] = value;
      arch_sp = arch_sp - 8'd1;
   endfunction

   function automatic logic [7:0] stack_pop();
      arch_sp = arch_sp + 8'd1;
      return arch_stack[arch_sp];
   endfunction

   // executes one instruction on the bench state and returns what the unit reports
   function automatic rsp_item_type execute_instruction(input req_item_type rq);
      rsp_item_type rs;
      logic [15:0]  nxt;
      logic [15:0]  ret;
      logic [15:0]  offset;
      logic [7:0]   lo;
      logic [7:0]   hi;
      logic         taken;
      logic         unsup;
      int           cond;
      nxt   = arch_pc;
      taken = 1'b0;
      unsup = 1'b0;
      cond  = -1;
      if (!arch_halted) begin
         case (rq.operation)
            OP_BRK: begin
               if (arch_sp < 8'd3) begin
                  arch_halted = 1'b1;
               end else begin
                  ret = arch_pc + 16'd2;
                  stack_push(ret[15:8]);
                  stack_push(ret[7:0]);
                  stack_push(arch_flags | F_U | F_B);
                  arch_flags = arch_flags | F_I;
                  nxt = brk_vector;
               end
            end
            OP_NOP:    nxt = arch_pc + 16'd1;
            OP_BIT_ZP, OP_BIT_AB: begin
               // n and v come from memory, z from the and with acc, the rest is kept
               arch_flags = (arch_flags & BIT_KEEP_MASK) | (rq.mem_lo & (F_N | F_V));
               if ((rq.mem_lo & rq.acc) == 8'h00) arch_flags = arch_flags | F_Z;
               nxt = arch_pc + ((rq.operation == OP_BIT_ZP) ? 16'd2 : 16'd3);
            end
            OP_CLC: begin
               arch_flags = arch_flags & CLC_MASK;
               nxt = arch_pc + 16'd1;
            end
            OP_SEC: begin
               arch_flags = arch_flags | F_C;
               nxt = arch_pc + 16'd1;
            end
            OP_CLI: begin
               arch_flags = arch_flags & CLI_MASK;
               nxt = arch_pc + 16'd1;
            end
            OP_SEI: begin
               arch_flags = arch_flags | F_I;
               nxt = arch_pc + 16'd1;
            end
            OP_CLV: begin
               arch_flags = arch_flags & CLV_MASK;
               nxt = arch_pc + 16'd1;
            end
            OP_CLD: begin
               arch_flags = arch_flags & CLD_MASK;
               nxt = arch_pc + 16'd1;
            end
            OP_SED: begin
               arch_flags = arch_flags | F_D;
               nxt = arch_pc + 16'd1;
            end
            OP_BPL: cond = int'((arch_flags & F_N) == 8'h00);
            OP_BMI: cond = int'((arch_flags & F_N) != 8'h00);
            OP_BVC: cond = int'((arch_flags & F_V) == 8'h00);
            OP_BVS: cond = int'((arch_flags & F_V) != 8'h00);
            OP_BCC: cond = int'((arch_flags & F_C) == 8'h00);
            OP_BCS: cond = int'((arch_flags & F_C) != 8'h00);
            OP_BNE: cond = int'((arch_flags & F_Z) == 8'h00);
            OP_BEQ: cond = int'((arch_flags & F_Z) != 8'h00);
            OP_JMP_AB: begin
               if (rq.operand == arch_pc) arch_halted = 1'b1;
               else nxt = rq.operand;
            end
            OP_JMP_IN: nxt = {rq.mem_hi, rq.mem_lo};
            OP_JSR: begin
               if (arch_sp < 8'd2) begin
                  arch_halted = 1'b1;
               end else begin
                  ret = arch_pc + 16'd2;
                  stack_push(ret[15:8]);
                  stack_push(ret[7:0]);
                  nxt = rq.operand;
               end
            end
            OP_RTS: begin
               if (arch_sp > 8'hFD) begin
                  arch_halted = 1'b1;
               end else begin
                  lo  = stack_pop();
                  hi  = stack_pop();
                  nxt = {hi, lo} + 16'd1;
               end
            end
            OP_RTI: begin
               if (arch_sp > 8'hFC) begin
                  arch_halted = 1'b1;
               end else begin
                  arch_flags = stack_pop();
                  lo  = stack_pop();
                  hi  = stack_pop();
                  nxt = {hi, lo};
                  // returning to an empty stack ends the run
                  if (arch_sp == SP_EMPTY) arch_halted = 1'b1;
               end
            end
            default: unsup = 1'b1;
         endcase
         if (cond >= 0) begin
            offset = {{8{rq.operand[7]}}, rq.operand[7:0]};
            if (cond == 1) begin
               taken = 1'b1;
               nxt   = arch_pc + 16'd2 + offset;
            end else begin
               nxt   = arch_pc + 16'd2;
            end
         end
         arch_pc = nxt;
      end
      rs.next_pc      = arch_pc;
      rs.status       = arch_flags;
      rs.stack_ptr    = arch_sp;
      rs.branch_taken = taken;
      rs.halted       = arch_halted;
      rs.unsupported  = unsup;
      return rs;
   endfunction

   // random instruction that keeps the unit running; the stack dives deep and climbs back
   function automatic req_item_type random_request();
      req_item_type rq;
      int           pick;
      bit           push_side;
      rq.operand = 16'($urandom);
      rq.mem_lo  = 8'($urandom);
      rq.mem_hi  = 8'($urandom);
      rq.acc     = 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick == 0) rq.operand = 16'hFFFF;
      if (pick == 1) rq.operand = 16'h0000;
      if (pick == 2) rq.operand[7:0] = $urandom_range(0, 1) ? 8'h7F : 8'h80;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         case ($urandom_range(0, 9))
            0: rq.operation = OP_NOP;
            1: rq.operation = OP_BIT_ZP;
            2: rq.operation = OP_BIT_AB;
            3: rq.operation = OP_CLC;
            4: rq.operation = OP_SEC;
            5: rq.operation = OP_CLI;
            6: rq.operation = OP_SEI;
            7: rq.operation = OP_CLV;
            8: rq.operation = OP_CLD;
            default: rq.operation = OP_SED;
         endcase
      end else if (pick < 50) begin
         case ($urandom_range(0, 7))
            0: rq.operation = OP_BPL;
            1: rq.operation = OP_BMI;
            2: rq.operation = OP_BVC;
            3: rq.operation = OP_BVS;
            4: rq.operation = OP_BCC;
            5: rq.operation = OP_BCS;
            6: rq.operation = OP_BNE;
            default: rq.operation = OP_BEQ;
         endcase
      end else if (pick < 62) begin
         rq.operation = $urandom_range(0, 1) ? OP_JMP_AB : OP_JMP_IN;
      end else if (pick < 90) begin
         if (arch_sp < 8'h40) stack_dive = 1'b0;
         if (arch_sp > 8'hF0) stack_dive = 1'b1;
         push_side = stack_dive ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) < 3);
         if (push_side) rq.operation = $urandom_range(0, 1) ? OP_JSR : OP_BRK;
         else rq.operation = $urandom_range(0, 1) ? OP_RTS : OP_RTI;
      end else begin
         rq.operation = 8'($urandom);
      end
      // steer clear of every halting case, those are kept for the end of the run
      case (rq.operation)
         OP_BRK:    if (arch_sp < 8'd3) rq.operation = OP_NOP;
         OP_JSR:    if (arch_sp < 8'd2) rq.operation = OP_NOP;
         OP_RTS:    if (arch_sp > 8'hFD) rq.operation = OP_NOP;
         OP_RTI:    if (arch_sp >= 8'hFC) rq.operation = OP_NOP;
         OP_JMP_AB: if (rq.operand == arch_pc) rq.operand = ~arch_pc;
         default: ;
      endcase
      return rq;
   endfunction

   // drives one request, then records its outcome once the unit has taken it
   task automatic send_request(input req_item_type rq, input logic typed,
                               input rsp_item_type typed_outcome);
      int gap;
      gap = pick_wait(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rq;
      do @(posedge clock); while (req_tready !== 1'b1);
      // the model always advances, a typed outcome only replaces what gets checked
      if (typed) begin
         void'(execute_instruction(rq));
         instr_outcomes.push_back(typed_outcome);
      end else begin
         instr_outcomes.push_back(execute_instruction(rq));
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (instr_outcomes.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   // apb write of the brk vector followed by a read back
   task automatic set_brk_vector(input logic [15:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_BRK_VEC;
      csr_pwdata  <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      brk_vector = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[15:0] !== value) begin
         mismatches++;
         if (mismatches <= 10)
            $display("brk vector read back: expected %h, got %h", value, csr_prdata[15:0]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // drives the unit into one of its halting cases, then checks that it stays frozen
   task automatic run_to_halt();
      int kind;
      kind = $urandom_range(0, 5);
      case (kind)
         0, 1: begin
            // stack full, by brk or by jsr
            while (arch_sp >= 8'd2)
               send_request(stim(OP_JSR, 16'($urandom), 8'h00, 8'h00, 8'h00), 1'b0, '0);
            send_request(stim((kind == 0) ? OP_BRK : OP_JSR, 16'($urandom),
                              8'h00, 8'h00, 8'h00), 1'b0, '0);
         end
         2, 3: begin
            // stack empty, by rts or by rti
            while (arch_sp <= 8'hFD)
               send_request(stim(OP_RTS, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, '0);
            send_request(stim((kind == 2) ? OP_RTS : OP_RTI, 16'h0000, 8'h00, 8'h00, 8'h00),
                         1'b0, '0);
         end
         4: begin
            // interrupt return that empties the stack completes and then halts
            while (arch_sp <= 8'hFD)
               send_request(stim(OP_RTS, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, '0);
            send_request(stim((arch_sp == SP_EMPTY) ? OP_BRK : OP_JSR, 16'($urandom),
                              8'h00, 8'h00, 8'h00), 1'b0, '0);
            send_request(stim(OP_RTI, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, '0);
         end
         default: begin
            // jump to itself
            send_request(stim(OP_JMP_AB, arch_pc, 8'h00, 8'h00, 8'h00), 1'b0, '0);
         end
      endcase
      repeat (12) send_request(random_request(), 1'b0, '0);
   endtask

   // result side: random stalls, each result checked against the oldest outcome
   initial begin : result_sink
      rsp_item_type got;
      rsp_item_type exp_item;
      int           gap;
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         gap = pick_wait(rsp_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got = rsp_tdata[RSP_ITEM_W-1:0];
         if (instr_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result with no request outstanding: pc %h status %h sp %h",
                        got.next_pc, got.status, got.stack_ptr);
         end else begin
            exp_item = instr_outcomes.pop_front();
            if (got.next_pc !== exp_item.next_pc || got.status !== exp_item.status ||
                got.stack_ptr !== exp_item.stack_ptr ||
                got.branch_taken !== exp_item.branch_taken ||
                got.halted !== exp_item.halted || got.unsupported !== exp_item.unsupported) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: expected pc %h st %h sp %h bt %b h %b u %b,",
                            " got pc %h st %h sp %h bt %b h %b u %b"},
                           exp_item.next_pc, exp_item.status, exp_item.stack_ptr,
                           exp_item.branch_taken, exp_item.halted, exp_item.unsupported,
                           got.next_pc, got.status, got.stack_ptr, got.branch_taken,
                           got.halted, got.unsupported);
            end
         end
      end
   end

   initial begin : request_source
      int i;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      mismatches  = 0;
      req_calm    = 0;
      rsp_calm    = 0;
      stack_dive  = 1'b1;
      arch_pc     = 16'h0000;
      arch_sp     = SP_EMPTY;
      arch_flags  = 8'h00;
      arch_halted = 1'b0;
      brk_vector  = 16'h0000;

      // directed walk from reset; outcomes typed in only where obvious
      script[0]  = {stim(OP_NOP, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b1,
                    want(16'h0001, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0)};
      // unknown opcode with every field at its top: nothing moves
      script[1]  = {stim(OP_UNKNOWN, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                    want(16'h0001, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b1)};
      // bit sets n and v from memory, z since memory and acc share no bit
      script[2]  = {stim(OP_BIT_ZP, 16'h00FF, 8'hFF, 8'h00, 8'h00), 1'b1,
                    want(16'h0003, 8'hC2, 8'hFF, 1'b0, 1'b0, 1'b0)};
      script[3]  = {stim(OP_BMI, 16'h007F, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[4]  = {stim(OP_BPL, 16'h0080, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[5]  = {stim(OP_BVS, 16'hFF80, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[6]  = {stim(OP_BEQ, 16'h00FE, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[7]  = {stim(OP_CLV, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[8]  = {stim(OP_BVC, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[9]  = {stim(OP_SEC, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[10] = {stim(OP_BCS, 16'h00FF, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[11] = {stim(OP_CLC, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[12] = {stim(OP_BCC, 16'h0040, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[13] = {stim(OP_BCS, 16'h0010, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[14] = {stim(OP_CLI, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[15] = {stim(OP_SEI, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[16] = {stim(OP_CLD, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[17] = {stim(OP_SED, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[18] = {stim(OP_BIT_AB, 16'h1234, 8'h3F, 8'h00, 8'h01), 1'b0, rsp_item_type'(0)};
      script[19] = {stim(OP_BNE, 16'h0005, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      // nested call and interrupt, unwound in order
      script[20] = {stim(OP_JSR, 16'hFFFF, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[21] = {stim(OP_BRK, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[22] = {stim(OP_RTI, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[23] = {stim(OP_RTS, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[24] = {stim(OP_JMP_AB, 16'h0000, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};
      script[25] = {stim(OP_JMP_IN, 16'h0000, 8'hFF, 8'hFF, 8'h00), 1'b0, rsp_item_type'(0)};
      // branch forward from the top of memory wraps to page zero
      script[26] = {stim(OP_BPL, 16'h007F, 8'h00, 8'h00, 8'h00), 1'b0, rsp_item_type'(0)};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_brk_vector(16'hFFFF);
      for (i = 0; i < SCRIPT_LEN; i++)
         send_request(script[i].stim, script[i].typed, script[i].want);
      wait_idle();

      set_brk_vector(16'h0000);
      repeat (210) send_request(random_request(), 1'b0, '0);
      wait_idle();

      set_brk_vector(16'($urandom));
      repeat (210) send_request(random_request(), 1'b0, '0);
      wait_idle();

      set_brk_vector(16'($urandom));
      repeat (190) send_request(random_request(), 1'b0, '0);
      run_to_halt();
      wait_idle();

      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
